>>> hw/rtl/rpn_pkg.sv
package rpn_pkg;

    // Action codes carried in the request.
    localparam logic [2:0] ACT_PUSH = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;
    localparam logic [2:0] ACT_SQRT = 3'd5;
    localparam logic [2:0] ACT_POP  = 3'd6;
    localparam logic [2:0] ACT_PEEK = 3'd7;

    // Status codes returned with every result.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DIV0    = 3'd1;
    localparam logic [2:0] ST_NEGSQRT = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic [2:0]          action;
        logic signed [31:0]  push_value;
    } rpn_req_t;

    typedef struct packed {
        logic signed [31:0]  top_value;
        logic [2:0]          status;
        logic [6:0]          depth;
    } rpn_rsp_t;

    typedef struct packed {
        logic                start;
        alu_op_t             op;
        logic signed [31:0]  a;
        logic signed [31:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic                done;
        logic signed [31:0]  value;
    } alu_rsp_t;

endpackage

>>> hw/rtl/rpn_alu.sv
module rpn_alu
    import rpn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 31;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_ITER,
        A_FIN
    } alu_state_t;

    alu_state_t          state_reg, state_next;
    logic                done_reg, done_next;
    logic signed [31:0]  value_reg, value_next;
    logic [5:0]          cnt_reg, cnt_next;

    // Datapath registers.
    logic signed [63:0]  prod_reg;
    logic [34:0]         rem_reg, rem_next;
    logic [63:0]         sh_reg, sh_next;
    logic [32:0]         q_reg, q_next;
    logic [31:0]         bmag_reg;
    logic                neg_reg;
    logic                big_reg;
    logic                div_reg;

    logic signed [31:0]  a_in, b_in;
    logic [31:0]         a_mag, b_mag;
    logic [63:0]         num_mag;
    logic                div_big;
    logic [61:0]         sqrt_n;
    logic signed [32:0]  sum;
    logic signed [63:0]  mshift;
    logic [34:0]         sub_x, sub_y;
    logic [35:0]         diff;
    logic                ge;
    logic [32:0]         q_neg;

    assign a_in  = req.a;
    assign b_in  = req.b;
    assign a_mag = a_in[31] ? 32'(-a_in) : a_in;
    assign b_mag = b_in[31] ? 32'(-b_in) : b_in;
    assign num_mag = 64'(a_mag) << FRAC_BITS;
    // A quotient of 2^33 or more saturates whatever its sign.
    assign div_big = (num_mag >> 33) >= 64'(b_mag);
    assign sqrt_n  = 62'(a_mag) << FRAC_BITS;

    assign sum = (req.op == ALU_SUB) ? ({a_in[31], a_in} - {b_in[31], b_in})
                                     : ({a_in[31], a_in} + {b_in[31], b_in});
    assign mshift = prod_reg >>> FRAC_BITS;

    // The shared subtractor: one quotient bit or one root bit per cycle.
    assign sub_x = div_reg ? {rem_reg[33:0], sh_reg[63]}
                           : {rem_reg[32:0], sh_reg[63:62]};
    assign sub_y = div_reg ? {3'b000, bmag_reg}
                           : {2'b00, q_reg[30:0], 2'b01};
    assign diff  = {1'b0, sub_x} - {1'b0, sub_y};
    assign ge    = !diff[35];
    assign q_neg = 33'd0 - q_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        cnt_next   = cnt_reg;
        rem_next   = ge ? diff[34:0] : sub_x;
        q_next     = {q_reg[31:0], ge};
        sh_next    = div_reg ? {sh_reg[62:0], 1'b0} : {sh_reg[61:0], 2'b00};
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        ALU_ADD, ALU_SUB:
                        begin
                            done_next = 1'b1;
                            if (sum[32] != sum[31])
                                value_next = sum[32] ? SAT_MIN : SAT_MAX;
                            else
                                value_next = sum[31:0];
                        end
                        ALU_MUL:
                            state_next = A_MUL;
                        ALU_DIV:
                        begin
                            state_next = div_big ? A_FIN : A_ITER;
                            cnt_next   = 6'(DIV_STEPS - 1);
                            rem_next   = 35'(num_mag[63:33]);
                            sh_next    = {num_mag[32:0], 31'd0};
                            q_next     = '0;
                        end
                        ALU_SQRT:
                        begin
                            state_next = A_ITER;
                            cnt_next   = 6'(SQRT_STEPS - 1);
                            rem_next   = '0;
                            sh_next    = {sqrt_n, 2'b00};
                            q_next     = '0;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            A_MUL:
            begin
                state_next = A_IDLE;
                done_next  = 1'b1;
                if (mshift[63:31] != {33{mshift[31]}})
                    value_next = mshift[63] ? SAT_MIN : SAT_MAX;
                else
                    value_next = mshift[31:0];
            end
            A_ITER:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                state_next = A_IDLE;
                done_next  = 1'b1;
                if (!div_reg)
                    value_next = q_reg[31:0];
                else if (big_reg)
                    value_next = neg_reg ? SAT_MIN : SAT_MAX;
                else if (neg_reg)
                    value_next = (q_reg > 33'h0_8000_0000) ? SAT_MIN : q_neg[31:0];
                else
                    value_next = (q_reg > 33'h0_7FFF_FFFF) ? SAT_MAX : q_reg[31:0];
            end
            default:
                state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            value_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            value_reg <= value_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        if (state_reg == A_IDLE && req.start)
        begin
            prod_reg <= 64'(a_in) * 64'(b_in);
            bmag_reg <= b_mag;
            neg_reg  <= a_in[31] ^ b_in[31];
            big_reg  <= div_big;
            div_reg  <= (req.op == ALU_DIV);
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

>>> hw/rtl/rpn_stack_calculator.sv
// Reverse Polish calculator over a stack of signed fixed-point values.
//
// A request (action and push value) is taken at a rising edge where start is
// high and busy is low. Exactly one result follows per request: done is high
// for one cycle while result holds the new top of stack (zero when empty),
// the status and the low 7 bits of the stack depth. The receiver cannot hold
// a result off, so it must sample it in that cycle.
//
// Push, pop, peek and any request that ends in an error finish in the
// execute state; add, subtract, multiply, divide and square root wait for
// the arithmetic unit, whose shared subtractor produces divide and square
// root results one bit per cycle. busy stays high until the result is
// produced, so one request is in work at a time; a new request may be
// accepted in the same cycle that done is shown.
//
// Reset empties the stack at once; stack entries are not cleared since only
// entries below the current depth are ever used.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rpn_req_t request,
    output logic     done,
    output rpn_rsp_t result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [31:0]  top_reg, top_next;
    logic                done_reg;
    rpn_rsp_t            res_reg, res_next;
    logic [2:0]          act_reg;
    logic signed [31:0]  pv_reg;

    logic signed [31:0]  mem [STACK_DEPTH];
    logic signed [31:0]  rdata_reg;
    logic [AW-1:0]       rd_addr;
    logic                we;
    logic [AW-1:0]       wa;
    logic signed [31:0]  wd;

    logic                fin;
    logic [2:0]          status;
    logic                has1, has2, full;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    rpn_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign busy = (state_reg != S_IDLE);
    assign has1 = (count_reg != '0);
    assign has2 = (count_reg >= CW'(2));
    assign full = (count_reg == CW'(STACK_DEPTH));
    // The entry below the top; read while idle so it is ready for execution.
    assign rd_addr = AW'(count_reg - CW'(2));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        fin         = 1'b0;
        status      = ST_OK;
        we          = 1'b0;
        wa          = AW'(count_reg - CW'(2));
        wd          = alu_rsp.value;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        alu_req.a     = rdata_reg;
        alu_req.b     = top_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (act_reg) inside
                    ACT_PUSH:
                    begin
                        fin = 1'b1;
                        if (full)
                            status = ST_OVER;
                        else
                        begin
                            we         = 1'b1;
                            wa         = AW'(count_reg);
                            wd         = pv_reg;
                            top_next   = pv_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                    begin
                        if (!has2)
                        begin
                            fin    = 1'b1;
                            status = ST_UNDER;
                        end
                        else if (act_reg == ACT_DIV && top_reg == '0)
                        begin
                            fin    = 1'b1;
                            status = ST_DIV0;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            unique case (act_reg) inside
                                ACT_ADD: alu_req.op = ALU_ADD;
                                ACT_SUB: alu_req.op = ALU_SUB;
                                ACT_MUL: alu_req.op = ALU_MUL;
                                default: alu_req.op = ALU_DIV;
                            endcase
                        end
                    end
                    ACT_SQRT:
                    begin
                        if (!has1)
                        begin
                            fin    = 1'b1;
                            status = ST_UNDER;
                        end
                        else if (top_reg[31])
                        begin
                            fin    = 1'b1;
                            status = ST_NEGSQRT;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_SQRT;
                            alu_req.a     = top_reg;
                        end
                    end
                    ACT_POP:
                    begin
                        fin = 1'b1;
                        if (!has1)
                            status = ST_UNDER;
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            top_next   = has2 ? rdata_reg : '0;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                        if (!has1)
                            status = ST_UNDER;
                    end
                endcase
                state_next = fin ? S_IDLE : S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    fin        = 1'b1;
                    we         = 1'b1;
                    top_next   = alu_rsp.value;
                    state_next = S_IDLE;
                    if (act_reg == ACT_SQRT)
                        wa = AW'(count_reg - CW'(1));
                    else
                        count_next = count_reg - CW'(1);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        res_next.top_value = top_next;
        res_next.status    = status;
        res_next.depth     = 7'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            done_reg  <= fin;
            if (fin)
                res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            act_reg <= request.action;
            pv_reg  <= request.push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[rd_addr];
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond stack depth");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> count_reg == $past(count_reg))
        else $error("error result changed the stack count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (top_reg == '0))
        else $error("empty stack holds a non-zero top");

endmodule

>>> sim/tb_rpn_stack_calculator.sv
module tb_rpn_stack_calculator;
    import rpn_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 50;

    localparam logic signed [31:0] FX_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FX_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] FX_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] FX_HALF = 32'sh0000_8000;
    localparam logic signed [31:0] FX_LSB  = 32'sh0000_0001;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    rpn_req_t request = '0;
    logic     busy;
    logic     done;
    rpn_rsp_t result;

    logic signed [31:0] shadow_stack [STACK_DEPTH];
    int                 shadow_count = 0;
    rpn_rsp_t           expected_results [$];

    int errors       = 0;
    int quiet_cycles = 0;
    int n_requests   = 0;
    int action_seen [8];
    int status_seen [8];
    int burst_left   = 0;
    bit steady       = 1'b0;

    always #5 clk = ~clk;

    rpn_stack_calculator #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(FX_MAX))
            return FX_MAX;
        if (v < longint'(FX_MIN))
            return FX_MIN;
        return v[31:0];
    endfunction

    // The arithmetic shift of the full product rounds toward minus infinity.
    function automatic logic signed [31:0] fx_product(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        longint la;
        longint lb;
        la = a;
        lb = b;
        return clamp32((la * lb) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] fx_quotient(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        longint num;
        longint den;
        num = a;
        den = b;
        num = num <<< FRAC_BITS;
        return clamp32(num / den);
    endfunction

    // Digit-by-digit integer square root of x scaled up by the fraction bits.
    function automatic logic signed [31:0] fx_root(input logic signed [31:0] x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = x;
        rem  = rem << FRAC_BITS;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    function automatic rpn_rsp_t calc_apply(input rpn_req_t req);
        rpn_rsp_t           rsp;
        logic [2:0]         st;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] r;
        longint             la;
        longint             lb;
        st = ST_OK;
        r  = '0;
        case (req.action)
            ACT_PUSH:
            begin
                if (shadow_count >= STACK_DEPTH)
                    st = ST_OVER;
                else
                begin
                    shadow_stack[shadow_count] = req.push_value;
                    shadow_count++;
                end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
            begin
                if (shadow_count < 2)
                    st = ST_UNDER;
                else
                begin
                    b  = shadow_stack[shadow_count - 1];
                    a  = shadow_stack[shadow_count - 2];
                    la = a;
                    lb = b;
                    case (req.action)
                        ACT_ADD: r = clamp32(la + lb);
                        ACT_SUB: r = clamp32(la - lb);
                        ACT_MUL: r = fx_product(a, b);
                        default:
                        begin
                            if (b == 0)
                                st = ST_DIV0;
                            else
                                r = fx_quotient(a, b);
                        end
                    endcase
                    if (st == ST_OK)
                    begin
                        shadow_stack[shadow_count - 2] = r;
                        shadow_count--;
                    end
                end
            end
            default:
            begin
                if (shadow_count < 1)
                    st = ST_UNDER;
                else if (req.action == ACT_SQRT)
                begin
                    if (shadow_stack[shadow_count - 1] < 0)
                        st = ST_NEGSQRT;
                    else
                        shadow_stack[shadow_count - 1] = fx_root(shadow_stack[shadow_count - 1]);
                end
                else if (req.action == ACT_POP)
                    shadow_count--;
            end
        endcase
        rsp.top_value = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
        rsp.status    = st;
        rsp.depth     = shadow_count[6:0];
        return rsp;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return FX_MAX;
            2: return FX_MIN;
            3: return ($urandom_range(0, 20) - 10) * FX_ONE;
            4: return $urandom_range(0, 262144) - 131072;
            5: return ($urandom_range(0, 1) == 1) ? FX_LSB : -FX_LSB;
            default: return $urandom;
        endcase
    endfunction

    // Mode 0 keeps the depth roughly level, mode 1 grows it and mode 2 shrinks it.
    function automatic logic [2:0] pick_action(input int mode);
        int push_pct;
        push_pct = (mode == 0) ? 45 : (mode == 1) ? 75 : 15;
        if (shadow_count < 2 && $urandom_range(0, 4) != 0)
            return ACT_PUSH;
        if (shadow_count >= STACK_DEPTH && $urandom_range(0, 4) != 0)
            push_pct = 0;
        if ($urandom_range(0, 99) < push_pct)
            return ACT_PUSH;
        case ($urandom_range(0, 6))
            0: return ACT_ADD;
            1: return ACT_SUB;
            2: return ACT_MUL;
            3: return ACT_DIV;
            4: return ACT_SQRT;
            5: return ACT_POP;
            default: return ACT_PEEK;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] act, input logic signed [31:0] val);
        rpn_req_t req;
        rpn_rsp_t rsp;
        req.action     = act;
        req.push_value = val;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        rsp = calc_apply(req);
        expected_results.push_back(rsp);
        action_seen[act]++;
        status_seen[rsp.status]++;
        n_requests++;
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Requests go out in bursts; a gap follows each burst unless idling is off.
    task automatic issue(input logic [2:0] act, input logic signed [31:0] val);
        send_request(act, val);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (!steady)
                hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(10, 45)
                                                     : $urandom_range(1, 6));
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_stack();
        issue(ACT_PEEK, pick_value());
        issue(ACT_POP, pick_value());
        issue(ACT_SQRT, pick_value());
        issue(ACT_ADD, pick_value());
        issue(ACT_PUSH, FX_ONE);
        issue(ACT_SUB, pick_value());
        issue(ACT_DIV, pick_value());
        issue(ACT_PEEK, pick_value());
        issue(ACT_POP, pick_value());
    endtask

    task automatic test_saturation_and_errors();
        issue(ACT_PUSH, FX_MAX);
        issue(ACT_PUSH, FX_MAX);
        issue(ACT_ADD, '0);
        issue(ACT_PUSH, '0);
        issue(ACT_DIV, '0);
        issue(ACT_POP, '0);
        issue(ACT_PUSH, FX_HALF);
        issue(ACT_DIV, '1);
        issue(ACT_PUSH, FX_MIN);
        issue(ACT_MUL, '0);
        issue(ACT_PUSH, FX_LSB);
        issue(ACT_SUB, '1);
        issue(ACT_SQRT, '0);
        // Half of minus one step must round down to minus one step.
        issue(ACT_PUSH, -FX_LSB);
        issue(ACT_PUSH, FX_HALF);
        issue(ACT_MUL, '0);
        issue(ACT_POP, '0);
        issue(ACT_POP, '0);
        issue(ACT_PUSH, FX_MAX);
        issue(ACT_SQRT, '0);
        issue(ACT_PUSH, '0);
        issue(ACT_SQRT, '1);
        issue(ACT_PEEK, '0);
        issue(ACT_POP, '0);
        issue(ACT_POP, '0);
    endtask

    task automatic test_full_stack();
        while (shadow_count < STACK_DEPTH)
            issue(ACT_PUSH, pick_value());
        issue(ACT_PUSH, pick_value());
        issue(ACT_PUSH, pick_value());
        issue(ACT_PEEK, pick_value());
        issue(ACT_SQRT, pick_value());
        issue(ACT_ADD, pick_value());
        issue(ACT_PUSH, pick_value());
        issue(ACT_PUSH, pick_value());
        while (shadow_count > 0)
            issue(($urandom_range(0, 2) != 0) ? ACT_POP : pick_action(2), pick_value());
        issue(ACT_POP, pick_value());
    endtask

    task automatic test_pause_until_drained();
        issue(ACT_PUSH, 3 * FX_ONE);
        issue(ACT_PUSH, 2 * FX_ONE);
        issue(ACT_DIV, pick_value());
        wait_for_results();
        issue(ACT_SQRT, pick_value());
        issue(ACT_PEEK, pick_value());
        wait_for_results();
        issue(ACT_POP, pick_value());
    endtask

    task automatic test_random_mix();
        int mode;
        int phase_left;
        mode       = 0;
        phase_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 120);
                steady     = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if ($urandom_range(0, 249) == 0)
                wait_for_results();
            issue(pick_action(mode), pick_value());
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        rpn_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: top %h status %0d depth %0d",
                         $realtime, result.top_value, result.status, result.depth);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.top_value !== want.top_value)
                begin
                    errors++;
                    $display("%0t: top_value mismatch: expected %h, actual %h",
                             $realtime, want.top_value, result.top_value);
                end
                if (result.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, want.status, result.status);
                end
                if (result.depth !== want.depth)
                begin
                    errors++;
                    $display("%0t: depth mismatch: expected %0d, actual %0d",
                             $realtime, want.depth, result.depth);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result for %0d cycles", $realtime, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        wait_for_results();
        test_saturation_and_errors();
        wait_for_results();
        test_full_stack();
        wait_for_results();
        test_pause_until_drained();
        wait_for_results();
        test_random_mix();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: push %0d add %0d sub %0d mul %0d div %0d sqrt %0d pop %0d peek %0d",
                 n_requests, action_seen[ACT_PUSH], action_seen[ACT_ADD], action_seen[ACT_SUB],
                 action_seen[ACT_MUL], action_seen[ACT_DIV], action_seen[ACT_SQRT],
                 action_seen[ACT_POP], action_seen[ACT_PEEK]);
        $display("Statuses: ok %0d, divide by zero %0d, negative root %0d, underflow %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_DIV0], status_seen[ST_NEGSQRT],
                 status_seen[ST_UNDER], status_seen[ST_OVER]);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
